### hw/rtl/lcdcd_pkg.sv
// Shared constants, types and helper functions of the LCD column driver bank.
package lcdcd_pkg;

   localparam int NUM_DRIVERS     = 10;
   localparam int RAM_PER_DRIVER  = 256;
   localparam int VISIBLE_COLUMNS = 50;
   localparam int RAM_DEPTH       = NUM_DRIVERS * RAM_PER_DRIVER;
   localparam int RAM_AW          = $clog2(RAM_DEPTH);
   localparam int SEL_W           = 10;
   localparam int DRV_W           = 4;
   localparam int PTR_W           = 8;
   localparam int COL_W           = 6;

   localparam logic       MODE_WRITE = 1'b0;
   localparam logic       MODE_READ  = 1'b1;

   localparam logic [7:0] PORT_SEL_LO_A  = 8'hB1;
   localparam logic [7:0] PORT_SEL_LO_B  = 8'hB9;
   localparam logic [7:0] PORT_SEL_HI_A  = 8'hB2;
   localparam logic [7:0] PORT_SEL_HI_B  = 8'hBA;
   localparam logic [7:0] PORT_PTR_FIRST = 8'hF0;
   localparam logic [7:0] PORT_PTR_LAST  = 8'hFE;
   localparam logic [7:0] PORT_DATA      = 8'hFF;

   localparam logic [7:0] PTR_PORT_READ_VALUE = 8'd64;
   localparam logic [7:0] PAGE_MASK           = 8'hC0;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic load_mask;
      logic draw_step;
      logic rd_issue;
      logic rd_emit;
      logic simple;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic draw_op;
      logic read_op;
      logic draw_final;
      logic out_free;
   } sts_type;

   function automatic logic col_visible(input logic [PTR_W-1:0] ptr);
      return {1'b0, ptr[COL_W-1:0]} < (COL_W+1)'(VISIBLE_COLUMNS);
   endfunction

   function automatic logic [DRV_W-1:0] lowest_index(input logic [NUM_DRIVERS-1:0] mask);
      logic [DRV_W-1:0] idx;
      idx = '0;
      for (int i = NUM_DRIVERS - 1; i >= 0; i--) begin
         if (mask[i]) idx = DRV_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [RAM_AW-1:0] ram_index(input logic [DRV_W-1:0] drv,
                                                   input logic [PTR_W-1:0] ptr);
      return RAM_AW'({drv, ptr});
   endfunction

endpackage

### hw/rtl/lcd_column_driver_bank.sv
// Bank of ten LCD column drivers reached through I/O port reads and writes.
//
// req_* carries one port access per word: tuser is the mode (0 write,
// 1 read), tdata holds the port address and the data byte. rsp_* returns
// the result words of each access, tlast marking the final one.
// Port FF writes give one draw word per selected driver with a visible
// column (lowest driver first); every other access gives a single word.
// Sequence after the accepting edge: a select, pointer or other access is
// decoded and its word loaded into the output register as the controller
// returns to idle; an FF read first does a registered RAM read, then loads
// its word; an FF write loads its draw mask, then gives its draw words one
// per cycle while rsp_tready allows (one blank word if it stores nothing).
// A new word is taken only once the previous access has handed all its
// results to the output register; each wait for rsp_tready delays it.
// After reset the display RAM, all 2560 bytes, is cleared one byte per cycle,
// and req_tready stays low until that is done.
// When the receiver holds rsp_tready low the output register keeps its
// word and the controller waits; nothing is dropped.
module lcd_column_driver_bank import lcdcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // port[7:0], data[15:8]
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // read_data[7:0], draw_driver[11:8],
                                   // draw_address[19:12], draw_byte[27:20], zero[31:28]
   output logic        rsp_tuser,  // draw_valid
   output logic        rsp_tlast
);

   cmd_type    cmd;
   sts_type    sts;
   logic [7:0] read_data;
   logic [3:0] draw_driver;
   logic [7:0] draw_address;
   logic [7:0] draw_byte;

   lcdcd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lcdcd_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_tuser),
      .req_port         (req_tdata[7:0]),
      .req_data         (req_tdata[15:8]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_read_data    (read_data),
      .rsp_draw_valid   (rsp_tuser),
      .rsp_draw_driver  (draw_driver),
      .rsp_draw_address (draw_address),
      .rsp_draw_byte    (draw_byte),
      .rsp_last         (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, draw_byte, draw_address, draw_driver, read_data};

endmodule

### hw/rtl/lcdcd_datapath.sv
// Datapath: select register, driver pointers, display RAM and result register.
module lcdcd_datapath import lcdcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        req_mode,
   input  logic [7:0]  req_port,
   input  logic [7:0]  req_data,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_draw_valid,
   output logic [3:0]  rsp_draw_driver,
   output logic [7:0]  rsp_draw_address,
   output logic [7:0]  rsp_draw_byte,
   output logic        rsp_last
);

   logic                   mode_ff;
   logic [7:0]             port_ff;
   logic [7:0]             data_ff;
   logic [SEL_W-1:0]       sel_ff, sel_in;
   logic [PTR_W-1:0]       ptr_ff [NUM_DRIVERS];
   logic [PTR_W-1:0]       ptr_in [NUM_DRIVERS];
   logic [NUM_DRIVERS-1:0] fresh_ff, fresh_in;
   logic [NUM_DRIVERS-1:0] pend_ff, pend_in;
   logic [RAM_AW-1:0]      clr_ff;
   logic [7:0]             mem [RAM_DEPTH];
   logic [7:0]             rd_q_ff;

   logic                   out_valid_ff;
   logic [7:0]             out_rd_ff;
   logic                   out_dv_ff;
   logic [DRV_W-1:0]       out_drv_ff;
   logic [7:0]             out_addr_ff;
   logic [7:0]             out_byte_ff;
   logic                   out_last_ff;

   logic [NUM_DRIVERS-1:0] sel_act;
   logic [NUM_DRIVERS-1:0] visible;
   logic [DRV_W-1:0]       cur_idx;
   logic [PTR_W-1:0]       cur_ptr;
   logic [PTR_W-1:0]       draw_next;
   logic                   port_sel_lo, port_sel_hi, port_ptr, port_dat;
   logic                   out_free;
   logic                   out_load;
   logic [7:0]             simple_rd;

   assign sel_act     = sel_ff[NUM_DRIVERS-1:0];
   assign port_sel_lo = (port_ff == PORT_SEL_LO_A) || (port_ff == PORT_SEL_LO_B);
   assign port_sel_hi = (port_ff == PORT_SEL_HI_A) || (port_ff == PORT_SEL_HI_B);
   assign port_ptr    = (port_ff >= PORT_PTR_FIRST) && (port_ff <= PORT_PTR_LAST);
   assign port_dat    = (port_ff == PORT_DATA);

   always_comb begin
      for (int i = 0; i < NUM_DRIVERS; i++) begin
         visible[i] = col_visible(ptr_ff[i]);
      end
   end

   // one pointer read port: pending draw mask while drawing, select mask on a data read
   assign cur_idx = lowest_index(cmd.draw_step ? pend_ff : sel_act);
   assign cur_ptr = ptr_ff[cur_idx];

   always_comb begin
      draw_next = cur_ptr + 8'd1;
      if (!col_visible(draw_next)) draw_next = draw_next & PAGE_MASK;
   end

   always_comb begin
      if (mode_ff == MODE_WRITE) begin
         simple_rd = 8'd0;
      end else if (port_sel_lo) begin
         simple_rd = sel_ff[7:0];
      end else if (port_ptr) begin
         simple_rd = PTR_PORT_READ_VALUE;
      end else begin
         simple_rd = 8'd0;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign out_load = cmd.simple || cmd.draw_step || cmd.rd_emit;

   assign sts.clear_done = (clr_ff == RAM_AW'(RAM_DEPTH - 1));
   assign sts.draw_op    = (mode_ff == MODE_WRITE) && port_dat;
   assign sts.read_op    = (mode_ff == MODE_READ) && port_dat && (|sel_act);
   assign sts.draw_final = (pend_ff & (pend_ff - NUM_DRIVERS'(1))) == '0;
   assign sts.out_free   = out_free;

   // next state of select, pointers, fresh bits and pending mask
   always_comb begin
      sel_in   = sel_ff;
      ptr_in   = ptr_ff;
      fresh_in = fresh_ff;
      pend_in  = pend_ff;
      if (cmd.simple && (mode_ff == MODE_WRITE)) begin
         if (port_sel_lo) begin
            sel_in = {sel_ff[SEL_W-1:8], data_ff};
         end else if (port_sel_hi) begin
            sel_in = {data_ff[SEL_W-9:0], sel_ff[7:0]};
         end else if (port_ptr) begin
            for (int i = 0; i < NUM_DRIVERS; i++) begin
               if (sel_act[i]) begin
                  ptr_in[i] = data_ff;
                  if (col_visible(data_ff)) fresh_in[i] = 1'b1;
               end
            end
         end
      end
      if (cmd.load_mask) pend_in = sel_act & visible;
      if (cmd.draw_step && (|pend_ff)) begin
         ptr_in[cur_idx]   = draw_next;
         fresh_in[cur_idx] = 1'b0;
         pend_in           = pend_ff & (pend_ff - NUM_DRIVERS'(1));
      end
      if (cmd.rd_issue) begin
         if (!fresh_ff[cur_idx]) ptr_in[cur_idx] = cur_ptr + 8'd1;
         fresh_in[cur_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         fresh_ff <= '1;
         pend_ff  <= '0;
         clr_ff   <= '0;
         for (int i = 0; i < NUM_DRIVERS; i++) ptr_ff[i] <= '0;
      end else begin
         sel_ff   <= sel_in;
         fresh_ff <= fresh_in;
         pend_ff  <= pend_in;
         ptr_ff   <= ptr_in;
         if (cmd.clear_step && !sts.clear_done) clr_ff <= clr_ff + RAM_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         port_ff <= req_port;
         data_ff <= req_data;
      end
   end

   // display RAM
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_ff] <= 8'd0;
      end else if (cmd.draw_step && (|pend_ff)) begin
         mem[ram_index(cur_idx, cur_ptr)] <= data_ff;
      end
      if (cmd.rd_issue) rd_q_ff <= mem[ram_index(cur_idx, cur_ptr)];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_rd_ff   <= 8'd0;
         out_dv_ff   <= 1'b0;
         out_drv_ff  <= '0;
         out_addr_ff <= 8'd0;
         out_byte_ff <= 8'd0;
         out_last_ff <= 1'b1;
         if (cmd.simple) begin
            out_rd_ff <= simple_rd;
         end else if (cmd.rd_emit) begin
            out_rd_ff <= rd_q_ff;
         end else if (|pend_ff) begin
            out_dv_ff   <= 1'b1;
            out_drv_ff  <= cur_idx;
            out_addr_ff <= cur_ptr;
            out_byte_ff <= data_ff;
            out_last_ff <= sts.draw_final;
         end
      end
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_read_data    = out_rd_ff;
   assign rsp_draw_valid   = out_dv_ff;
   assign rsp_draw_driver  = out_drv_ff;
   assign rsp_draw_address = out_addr_ff;
   assign rsp_draw_byte    = out_byte_ff;
   assign rsp_last         = out_last_ff;

endmodule

### hw/rtl/lcdcd_controller.sv
// Controller: sequences RAM clearing, word intake, draw loop and data reads.
module lcdcd_controller import lcdcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_DRAW   = 3'd3;
   localparam logic [2:0] ST_RDOUT  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (sts.draw_op) begin
               cmd.load_mask = 1'b1;
               state_in      = ST_DRAW;
            end else if (sts.read_op) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_RDOUT;
            end else if (sts.out_free) begin
               cmd.simple = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_DECODE;
            end
         end
         ST_DRAW: begin
            // one draw word per pending driver; an empty mask yields a single blank word
            if (sts.out_free) begin
               cmd.draw_step = 1'b1;
               if (sts.draw_final) state_in = ST_IDLE;
            end
         end
         ST_RDOUT: begin
            if (sts.out_free) begin
               cmd.rd_emit = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
